// ===== hw/rtl/ps2hp_pkg.sv =====
// Shared types and constants of the PS/2 host port.
`timescale 1ns / 1ps

package ps2hp_pkg;

   localparam int FIFO_DEPTH_DEF = 16;   // receive ring entries, holds one less byte
   localparam int GAP_LIMIT_RST  = 2000; // gap limit after reset, in microseconds
   localparam int Q_DEPTH        = 3;    // result queue entries
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 16;
   localparam int REQ_DATA_W     = 16;
   localparam int RSP_DATA_W     = 176;

   // frame bit positions
   localparam logic [3:0] BIT_START  = 4'd0;
   localparam logic [3:0] BIT_LAST_D = 4'd8;
   localparam logic [3:0] BIT_PARITY = 4'd9;
   localparam logic [3:0] BIT_STOP   = 4'd10;

   typedef enum logic [2:0] {
      OP_EDGE  = 3'd0,
      OP_TICK  = 3'd1,
      OP_SEND  = 3'd2,
      OP_READ  = 3'd3,
      OP_ABORT = 3'd4
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE    = 2'd0,
      CSR_GAP_LIMIT = 2'd1
   } csr_idx_type;

   typedef struct packed {
      logic        enable;
      logic [15:0] gap_limit;
   } cfg_type;

   // one result without the popped byte; the byte joins from the registered RAM read in the queue
   typedef struct packed {
      logic [31:0] command_failures;
      logic [31:0] commands_acked;
      logic [31:0] overruns;
      logic [31:0] framing_faults;
      logic [31:0] bytes_received;
      logic        read_valid;
      logic        tx_rejected;
      logic        tx_acked;
      logic        tx_done;
      logic        tx_busy;
      logic        data_drive;
   } res_type;

   // full result, laid out as rsp_tdata (last field lowest)
   typedef struct packed {
      logic [1:0]  pad;
      logic [31:0] command_failures;
      logic [31:0] commands_acked;
      logic [31:0] overruns;
      logic [31:0] framing_faults;
      logic [31:0] bytes_received;
      logic        read_valid;
      logic [7:0]  read_byte;
      logic        tx_rejected;
      logic        tx_acked;
      logic        tx_done;
      logic        tx_busy;
      logic        data_drive;
   } out_type;

endpackage

// ===== hw/rtl/ps2hp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ps2hp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ps2hp_core.sv =====
// Event engine: receive framing, transmit sequencing, FIFO pointers and counters.
`timescale 1ns / 1ps

module ps2hp_core
   import ps2hp_pkg::*;
#(
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic                          ev_valid,
   input  logic [2:0]                    opcode,
   input  logic                          data_level,
   input  logic [7:0]                    tx_byte,
   output logic                          ram_wr_en,
   output logic [$clog2(FIFO_DEPTH)-1:0] ram_wr_addr,
   output logic [7:0]                    ram_wr_data,
   output logic                          ram_rd_en,
   output logic [$clog2(FIFO_DEPTH)-1:0] ram_rd_addr,
   output res_type                       result
);

   localparam int AW = $clog2(FIFO_DEPTH);
   localparam logic [AW-1:0] PTR_LAST = AW'(FIFO_DEPTH - 1);

   logic [3:0]    rx_bit_ff, rx_bit_in;
   logic [7:0]    rx_shift_ff, rx_shift_in;
   logic          rx_par_ff, rx_par_in;
   logic          edge_seen_ff, edge_seen_in;
   logic [15:0]   gap_ff, gap_in;
   logic          tx_active_ff, tx_active_in;
   logic [3:0]    tx_bit_ff, tx_bit_in;
   logic [7:0]    tx_hold_ff, tx_hold_in;
   logic          drive_ff, drive_in;
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [31:0]   bytes_ff, bytes_in;
   logic [31:0]   frm_err_ff, frm_err_in;
   logic [31:0]   ovr_ff, ovr_in;
   logic [31:0]   acked_ff, acked_in;
   logic [31:0]   cmd_err_ff, cmd_err_in;

   logic          gap_drop;
   logic [3:0]    rx_bit_eff;
   logic [7:0]    rx_shift_eff;
   logic          rx_par_eff;
   logic          par_ok;
   logic [AW-1:0] wr_next;
   logic [AW-1:0] rd_next;
   logic          fifo_full;
   logic          fifo_empty;
   logic          done, ack, rejected, rvalid;

   // a long idle gap throws away the partial frame before this edge is used
   assign gap_drop     = edge_seen_ff && (gap_ff > cfg.gap_limit);
   assign rx_bit_eff   = gap_drop ? BIT_START : rx_bit_ff;
   assign rx_shift_eff = gap_drop ? 8'd0 : rx_shift_ff;
   assign rx_par_eff   = gap_drop ? 1'b0 : rx_par_ff;
   assign par_ok       = (^rx_shift_eff) ^ rx_par_eff;

   assign wr_next    = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + AW'(1);
   assign rd_next    = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + AW'(1);
   assign fifo_full  = (wr_next == rd_ptr_ff);
   assign fifo_empty = (rd_ptr_ff == wr_ptr_ff);

   always_comb begin
      rx_bit_in    = rx_bit_ff;
      rx_shift_in  = rx_shift_ff;
      rx_par_in    = rx_par_ff;
      edge_seen_in = edge_seen_ff;
      gap_in       = gap_ff;
      tx_active_in = tx_active_ff;
      tx_bit_in    = tx_bit_ff;
      tx_hold_in   = tx_hold_ff;
      drive_in     = drive_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      bytes_in     = bytes_ff;
      frm_err_in   = frm_err_ff;
      ovr_in       = ovr_ff;
      acked_in     = acked_ff;
      cmd_err_in   = cmd_err_ff;
      done         = 1'b0;
      ack          = 1'b0;
      rejected     = 1'b0;
      rvalid       = 1'b0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;

      if (ev_valid && cfg.enable) begin
         unique case (opcode)
            OP_EDGE: begin
               if (tx_active_ff) begin
                  if (tx_bit_ff >= 4'd1 && tx_bit_ff <= BIT_LAST_D) begin
                     drive_in  = tx_hold_ff[3'(tx_bit_ff - 4'd1)];
                     tx_bit_in = tx_bit_ff + 4'd1;
                  end else if (tx_bit_ff == BIT_PARITY) begin
                     drive_in  = ~(^tx_hold_ff);
                     tx_bit_in = tx_bit_ff + 4'd1;
                  end else if (tx_bit_ff == BIT_STOP) begin
                     drive_in  = 1'b1;
                     tx_bit_in = tx_bit_ff + 4'd1;
                  end else begin
                     // line released: device pulls data low to acknowledge
                     tx_active_in = 1'b0;
                     edge_seen_in = 1'b0;
                     gap_in       = '0;
                     rx_bit_in    = BIT_START;
                     rx_shift_in  = '0;
                     rx_par_in    = 1'b0;
                     done         = 1'b1;
                     ack          = ~data_level;
                     if (!data_level) begin
                        acked_in = acked_ff + 32'd1;
                     end else begin
                        cmd_err_in = cmd_err_ff + 32'd1;
                     end
                  end
               end else begin
                  edge_seen_in = 1'b1;
                  gap_in       = '0;
                  rx_bit_in    = rx_bit_eff;
                  rx_shift_in  = rx_shift_eff;
                  rx_par_in    = rx_par_eff;
                  if (rx_bit_eff == BIT_START) begin
                     if (data_level) begin
                        frm_err_in = frm_err_ff + 32'd1;
                     end else begin
                        rx_bit_in = 4'd1;
                     end
                  end else if (rx_bit_eff <= BIT_LAST_D) begin
                     rx_shift_in[3'(rx_bit_eff - 4'd1)] = rx_shift_eff[3'(rx_bit_eff - 4'd1)]
                                                          | data_level;
                     rx_bit_in = rx_bit_eff + 4'd1;
                  end else if (rx_bit_eff == BIT_PARITY) begin
                     rx_par_in = data_level;
                     rx_bit_in = BIT_STOP;
                  end else begin
                     if (data_level && par_ok) begin
                        if (fifo_full) begin
                           ovr_in = ovr_ff + 32'd1;
                        end else begin
                           ram_wr_en = 1'b1;
                           wr_ptr_in = wr_next;
                           bytes_in  = bytes_ff + 32'd1;
                        end
                     end else begin
                        frm_err_in = frm_err_ff + 32'd1;
                     end
                     rx_bit_in   = BIT_START;
                     rx_shift_in = '0;
                     rx_par_in   = 1'b0;
                  end
               end
            end
            OP_TICK: begin
               if (edge_seen_ff && gap_ff != 16'hFFFF) begin
                  gap_in = gap_ff + 16'd1;
               end
            end
            OP_SEND: begin
               if (tx_active_ff) begin
                  rejected = 1'b1;
               end else begin
                  tx_active_in = 1'b1;
                  tx_bit_in    = 4'd1;
                  tx_hold_in   = tx_byte;
                  drive_in     = 1'b0;
               end
            end
            OP_READ: begin
               if (!fifo_empty) begin
                  ram_rd_en = 1'b1;
                  rvalid    = 1'b1;
                  rd_ptr_in = rd_next;
               end
            end
            OP_ABORT: begin
               if (tx_active_ff) begin
                  tx_active_in = 1'b0;
                  cmd_err_in   = cmd_err_ff + 32'd1;
               end
               edge_seen_in = 1'b0;
               gap_in       = '0;
               rx_bit_in    = BIT_START;
               rx_shift_in  = '0;
               rx_par_in    = 1'b0;
               drive_in     = 1'b1;
            end
            default: begin
               // undefined opcodes are no event
            end
         endcase
      end
   end

   assign ram_wr_addr = wr_ptr_ff;
   assign ram_wr_data = rx_shift_eff;
   assign ram_rd_addr = rd_ptr_ff;

   always_comb begin
      result.data_drive       = drive_in;
      result.tx_busy          = tx_active_in;
      result.tx_done          = done;
      result.tx_acked         = ack;
      result.tx_rejected      = rejected;
      result.read_valid       = rvalid;
      result.bytes_received   = bytes_in;
      result.framing_faults   = frm_err_in;
      result.overruns         = ovr_in;
      result.commands_acked   = acked_in;
      result.command_failures = cmd_err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_bit_ff    <= BIT_START;
         rx_shift_ff  <= '0;
         rx_par_ff    <= 1'b0;
         edge_seen_ff <= 1'b0;
         gap_ff       <= '0;
         tx_active_ff <= 1'b0;
         tx_bit_ff    <= '0;
         tx_hold_ff   <= '0;
         drive_ff     <= 1'b1;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         bytes_ff     <= '0;
         frm_err_ff   <= '0;
         ovr_ff       <= '0;
         acked_ff     <= '0;
         cmd_err_ff   <= '0;
      end else begin
         rx_bit_ff    <= rx_bit_in;
         rx_shift_ff  <= rx_shift_in;
         rx_par_ff    <= rx_par_in;
         edge_seen_ff <= edge_seen_in;
         gap_ff       <= gap_in;
         tx_active_ff <= tx_active_in;
         tx_bit_ff    <= tx_bit_in;
         tx_hold_ff   <= tx_hold_in;
         drive_ff     <= drive_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         bytes_ff     <= bytes_in;
         frm_err_ff   <= frm_err_in;
         ovr_ff       <= ovr_in;
         acked_ff     <= acked_in;
         cmd_err_ff   <= cmd_err_in;
      end
   end

endmodule

// ===== hw/rtl/ps2hp_outq.sv =====
// Result register plus a small queue that decouples the response side.
`timescale 1ns / 1ps

module ps2hp_outq
   import ps2hp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  res_type in_result,
   input  logic [7:0] ram_rd_data,
   output logic    in_ready,
   output logic    out_valid,
   input  logic    out_ready,
   output out_type out_data
);

   localparam logic [1:0] QLAST = 2'(Q_DEPTH - 1);

   logic       s1_valid_ff;
   res_type    s1_ff;
   out_type    q_ff [Q_DEPTH];
   logic [1:0] head_ff, head_in;
   logic [1:0] tail_ff, tail_in;
   logic [1:0] qcnt_ff, qcnt_in;
   logic [1:0] cnt_ff, cnt_in;    // requests held in s1 and queue together
   logic       push, pop, take;
   out_type    entry;

   assign take      = in_valid && in_ready;
   assign in_ready  = (cnt_ff != 2'(Q_DEPTH));
   assign push      = s1_valid_ff;
   assign out_valid = (qcnt_ff != 2'd0);
   assign pop       = out_valid && out_ready;
   assign out_data  = q_ff[head_ff];

   // popped byte comes from the RAM read issued with the request
   always_comb begin
      entry                  = '0;
      entry.data_drive       = s1_ff.data_drive;
      entry.tx_busy          = s1_ff.tx_busy;
      entry.tx_done          = s1_ff.tx_done;
      entry.tx_acked         = s1_ff.tx_acked;
      entry.tx_rejected      = s1_ff.tx_rejected;
      entry.read_valid       = s1_ff.read_valid;
      entry.read_byte        = s1_ff.read_valid ? ram_rd_data : 8'd0;
      entry.bytes_received   = s1_ff.bytes_received;
      entry.framing_faults   = s1_ff.framing_faults;
      entry.overruns         = s1_ff.overruns;
      entry.commands_acked   = s1_ff.commands_acked;
      entry.command_failures = s1_ff.command_failures;
   end

   always_comb begin
      tail_in = tail_ff;
      head_in = head_ff;
      if (push) begin
         tail_in = (tail_ff == QLAST) ? 2'd0 : tail_ff + 2'd1;
      end
      if (pop) begin
         head_in = (head_ff == QLAST) ? 2'd0 : head_ff + 2'd1;
      end
      qcnt_in = qcnt_ff + {1'b0, push} - {1'b0, pop};
      cnt_in  = cnt_ff + {1'b0, take} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         head_ff     <= '0;
         tail_ff     <= '0;
         qcnt_ff     <= '0;
         cnt_ff      <= '0;
      end else begin
         s1_valid_ff <= take;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         qcnt_ff     <= qcnt_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_ff <= in_result;
      end
      if (push) begin
         q_ff[tail_ff] <= entry;
      end
   end

endmodule

// ===== hw/rtl/ps2_host_port.sv =====
// Top level of the PS/2 host port: register file, event engine, receive RAM, result queue.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+----------------------------------------
//  req      | in        | req_tvalid/req_tready  | tuser opcode, tdata level + tx byte
//  rsp      | out       | rsp_tvalid/rsp_tready  | tdata status flags, popped byte, counters
//  csr      | in        | csr_valid/csr_ready    | csr_index, csr_data
//
//  One request per cycle while req_tready is high; each gives one response after acceptance
//  (engine works on the request as it is taken, result register, queue).
//  The popped byte comes from a RAM with registered read, aligned with the result register.
//  Up to three requests in flight: req_tready depends only on that count, never on rsp_tready.
//  Synchronous reset clears control state and counters, drops queued results, gap limit 2000 us.
//  CSR writes are always accepted and are meant to happen only while the port is idle.
`timescale 1ns / 1ps

module ps2_host_port
   import ps2hp_pkg::*;
#(
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // data_level[0], tx_byte[8:1], zero fill
   input  logic [2:0]            req_tuser,  // opcode[2:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // data_drive[0], tx_busy[1], tx_done[2], tx_acked[3], tx_rejected[4], read_byte[12:5],
   // read_valid[13], bytes_received[45:14], framing_faults[77:46], overruns[109:78],
   // commands_acked[141:110], command_failures[173:142], zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int AW = $clog2(FIFO_DEPTH);

   logic        enable_ff;
   logic [15:0] gap_limit_ff;
   cfg_type     cfg;
   logic        accept;

   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [7:0]    ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [7:0]    ram_rd_data;
   res_type       core_result;
   out_type       rsp_word;

   // control registers, written any cycle
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         gap_limit_ff <= 16'(GAP_LIMIT_RST);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ENABLE:    enable_ff    <= csr_data[0];
            CSR_GAP_LIMIT: gap_limit_ff <= csr_data;
            default: begin
               // unmapped index: write dropped
            end
         endcase
      end
   end

   assign cfg.enable    = enable_ff;
   assign cfg.gap_limit = gap_limit_ff;

   // request handed to the engine in the cycle it is taken
   assign accept = req_tvalid && req_tready;

   ps2hp_core #(
      .FIFO_DEPTH(FIFO_DEPTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .ev_valid   (accept),
      .opcode     (req_tuser),
      .data_level (req_tdata[0]),
      .tx_byte    (req_tdata[8:1]),
      .ram_wr_en  (ram_wr_en),
      .ram_wr_addr(ram_wr_addr),
      .ram_wr_data(ram_wr_data),
      .ram_rd_en  (ram_rd_en),
      .ram_rd_addr(ram_rd_addr),
      .result     (core_result)
   );

   // receive ring storage; a read and a write never share a cycle
   ps2hp_ram #(
      .WIDTH(8),
      .DEPTH(FIFO_DEPTH)
   ) u_rx_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   ps2hp_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_result  (core_result),
      .ram_rd_data(ram_rd_data),
      .in_ready   (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (rsp_word)
   );

   assign rsp_tdata = rsp_word;

endmodule

// ===== hw/rtl/ps2hp_checker.sv =====
// Port-level checks of the PS/2 host port, bound to the top level.
`timescale 1ns / 1ps

module ps2hp_checker
   import ps2hp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response shown right after reset");

   a_byte_only_on_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[13] |-> rsp_tdata[12:5] == 8'd0)
      else $error("read byte nonzero without a pop");

   a_ack_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> rsp_tdata[2] && !rsp_tdata[1])
      else $error("acknowledge without a finished transmit");

   a_reject_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4] |-> rsp_tdata[1] && !rsp_tdata[2])
      else $error("transmit refused while idle");

endmodule

bind ps2_host_port ps2hp_checker u_ps2hp_checker (.*);
